// ===== rtl/core/qmm_pkg.sv =====
`default_nettype none

package qmm_pkg;

  // Input word: total thrust and the three torques, signed Q16.16
  typedef struct packed {
    logic signed [31:0] thrust;
    logic signed [31:0] roll_torque;
    logic signed [31:0] pitch_torque;
    logic signed [31:0] yaw_torque;
  } mix_in_t;

  // Result word: four motor commands, signed Q1.14
  typedef struct packed {
    logic signed [15:0] motor_front;
    logic signed [15:0] motor_back;
    logic signed [15:0] motor_left;
    logic signed [15:0] motor_right;
  } mix_out_t;

  // Configuration register map
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    RegInvHalfArm    = 2'd0,
    RegInvFourDrag   = 2'd1,
    RegInvThrustGain = 2'd2
  } cfg_reg_e;
  localparam logic [CfgW-1:0] CfgOneReset = 32'd65536;

  // Motor lanes
  localparam int unsigned NumMotors  = 4;
  localparam int unsigned MotorFront = 0;
  localparam int unsigned MotorBack  = 1;
  localparam int unsigned MotorLeft  = 2;
  localparam int unsigned MotorRight = 3;

  // Mixing: torque product Q.32 brought to Q.18
  localparam int unsigned ProdW   = 65;
  localparam int unsigned TorqSh  = 14;
  localparam int unsigned TorqW   = ProdW - TorqSh;  // 51
  localparam int unsigned MixW    = 53;
  localparam int unsigned DemW    = 51;              // positive demand, unsigned
  typedef logic [DemW-1:0] demand_t;

  // Scaling by thrust gain, saturation of S at 2^39
  localparam int unsigned HiW     = DemW - 32 + CfgW;  // 51
  localparam int unsigned LoW     = 64;
  localparam int unsigned SumW    = 83;
  localparam int unsigned SW      = 40;
  localparam int unsigned SqPad   = 14;

  // Square root: two result bits per stage
  localparam int unsigned RadW       = 56;
  localparam int unsigned RootW      = RadW / 2;
  localparam int unsigned RemW       = RootW + 2;
  localparam int unsigned SqrtStages = RootW / 2;
  typedef logic [RadW-1:0] rad_t;
  typedef logic [RootW-1:0] sq_root_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } root_acc_t;

  // Output mapping onto -1..1
  localparam int unsigned NW   = 29;
  localparam int unsigned VW   = 26;
  localparam int unsigned RcpW = 52;
  localparam int unsigned EstW = 16;
  localparam int unsigned RmW  = 12;
  localparam logic signed [NW-1:0] Centre   = 29'sd55410688;
  localparam logic signed [NW-1:0] NLim     = 29'sd28672000;
  localparam logic signed [NW-1:0] HalfSpan = 29'sd875;
  localparam logic [RmW-1:0]       Span     = 12'd1750;
  localparam logic [VW-1:0]        RecipM   = 26'd39268272;  // floor(2^36 / 1750)
  localparam int unsigned          RecipSh  = 36;
  localparam logic [15:0]          PosOne   = 16'sd16384;
  localparam logic [15:0]          NegOne   = -16'sd16384;

  // Cycles from an accepted word to its result strobe
  localparam int unsigned Latency = 8 + SqrtStages;

  // One step of the digit-by-digit square root
  function automatic root_acc_t root_step(root_acc_t a, logic [1:0] pair);
    logic [RemW-1:0] r;
    logic [RemW-1:0] trial;
    root_acc_t       y;
    r     = {a.rem[RemW-3:0], pair};
    trial = {a.root, 2'b01};
    if (r >= trial) begin
      y.rem  = r - trial;
      y.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      y.rem  = r;
      y.root = {a.root[RootW-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quadrotor_motor_mixer.sv =====
`default_nettype none

// Plus-configuration quadrotor motor mixer.
// Input channel: drive a thrust/torque word on in_i and raise start; the word
// is taken at a rising edge with start high and busy low. busy stays low, so
// a new word may be offered in every cycle (one word per cycle sustained).
// Result channel: done_o is high for exactly one cycle with the four motor
// commands on out_o. Results come out in input order; the depth is set by the
// two-stage torque mix, the two-stage thrust gain scaling, the 14-stage
// square root (two root bits per stage) and the four-stage output mapping.
// The receiver cannot hold results off; each word must be taken as shown.
// Configuration: write inv_half_arm (0), inv_four_drag (1) or
// inv_thrust_gain (2) through cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; other indexes are ignored. Write only while no word is in
// flight. cfg_ready_o is always high.
// Reset clears all pipeline valid bits, so nothing is shown until new words
// arrive, and sets the three registers to 1.0.

module quadrotor_motor_mixer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire qmm_pkg::mix_in_t             in_i,
  output logic                              done_o,
  output qmm_pkg::mix_out_t                 out_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [qmm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [qmm_pkg::CfgW-1:0]     cfg_data_i
);

  logic [qmm_pkg::CfgW-1:0]                        half_arm_q, four_drag_q, gain_q;
  logic                                            accept;
  logic                                            mix_vld, scale_vld, sqrt_vld;
  qmm_pkg::demand_t   [qmm_pkg::NumMotors-1:0]     dem;
  qmm_pkg::rad_t      [qmm_pkg::NumMotors-1:0]     rad;
  qmm_pkg::sq_root_t  [qmm_pkg::NumMotors-1:0]     root;
  logic [qmm_pkg::NumMotors-1:0][15:0]             cmd;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_arm_q  <= qmm_pkg::CfgOneReset;
      four_drag_q <= qmm_pkg::CfgOneReset;
      gain_q      <= qmm_pkg::CfgOneReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        qmm_pkg::RegInvHalfArm:    half_arm_q  <= cfg_data_i;
        qmm_pkg::RegInvFourDrag:   four_drag_q <= cfg_data_i;
        qmm_pkg::RegInvThrustGain: gain_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qmm_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .in_i        (in_i),
    .half_arm_i  (half_arm_q),
    .four_drag_i (four_drag_q),
    .valid_o     (mix_vld),
    .dem_o       (dem)
  );

  qmm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_vld),
    .dem_i   (dem),
    .gain_i  (gain_q),
    .valid_o (scale_vld),
    .rad_o   (rad)
  );

  qmm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_vld),
    .rad_i   (rad),
    .valid_o (sqrt_vld),
    .root_o  (root)
  );

  qmm_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sqrt_vld),
    .root_i  (root),
    .valid_o (done_o),
    .cmd_o   (cmd)
  );

  // Pack the result word
  assign out_o.motor_front = cmd[qmm_pkg::MotorFront];
  assign out_o.motor_back  = cmd[qmm_pkg::MotorBack];
  assign out_o.motor_left  = cmd[qmm_pkg::MotorLeft];
  assign out_o.motor_right = cmd[qmm_pkg::MotorRight];

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(qmm_pkg::Latency) done_o)
    else $error("accepted word produced no result");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, qmm_pkg::Latency))
    else $error("result without a matching accepted word");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.motor_front >= -16'sd16384 && out_o.motor_front <= 16'sd16384 &&
                out_o.motor_back  >= -16'sd16384 && out_o.motor_back  <= 16'sd16384 &&
                out_o.motor_left  >= -16'sd16384 && out_o.motor_left  <= 16'sd16384 &&
                out_o.motor_right >= -16'sd16384 && out_o.motor_right <= 16'sd16384))
    else $error("motor command outside -1..1");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qmm_mix.sv =====
`default_nettype none

module qmm_mix (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        valid_i,
  input  wire qmm_pkg::mix_in_t                            in_i,
  input  wire logic [qmm_pkg::CfgW-1:0]                    half_arm_i,
  input  wire logic [qmm_pkg::CfgW-1:0]                    four_drag_i,
  output logic                                             valid_o,
  output qmm_pkg::demand_t [qmm_pkg::NumMotors-1:0]        dem_o
);

  logic                                     vld1_q;
  logic signed [31:0]                       thrust_q;
  logic signed [qmm_pkg::ProdW-1:0]         roll_q, pitch_q, yaw_q;
  logic signed [qmm_pkg::ProdW-1:0]         roll_d, pitch_d, yaw_d;
  logic signed [32:0]                       arm_s, drag_s;

  logic signed [qmm_pkg::TorqW-1:0]         roll_t, pitch_t, yaw_t;
  logic signed [qmm_pkg::MixW-1:0]          mix [qmm_pkg::NumMotors];
  qmm_pkg::demand_t [qmm_pkg::NumMotors-1:0] dem_d, dem_q;
  logic                                     vld2_q;

  // Torque products against the arm and drag factors
  assign arm_s   = {1'b0, half_arm_i};
  assign drag_s  = {1'b0, four_drag_i};
  assign roll_d  = in_i.roll_torque * arm_s;
  assign pitch_d = in_i.pitch_torque * arm_s;
  assign yaw_d   = in_i.yaw_torque * drag_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    thrust_q <= in_i.thrust;
    roll_q   <= roll_d;
    pitch_q  <= pitch_d;
    yaw_q    <= yaw_d;
    dem_q    <= dem_d;
  end

  // Floor shift to Q.18, mix and clamp at zero
  assign roll_t  = $signed(roll_q[qmm_pkg::ProdW-1:qmm_pkg::TorqSh]);
  assign pitch_t = $signed(pitch_q[qmm_pkg::ProdW-1:qmm_pkg::TorqSh]);
  assign yaw_t   = $signed(yaw_q[qmm_pkg::ProdW-1:qmm_pkg::TorqSh]);

  always_comb begin
    mix[qmm_pkg::MotorFront] = qmm_pkg::MixW'(thrust_q) - qmm_pkg::MixW'(roll_t)
                               - qmm_pkg::MixW'(yaw_t);
    mix[qmm_pkg::MotorBack]  = qmm_pkg::MixW'(thrust_q) + qmm_pkg::MixW'(roll_t)
                               - qmm_pkg::MixW'(yaw_t);
    mix[qmm_pkg::MotorLeft]  = qmm_pkg::MixW'(thrust_q) - qmm_pkg::MixW'(pitch_t)
                               + qmm_pkg::MixW'(yaw_t);
    mix[qmm_pkg::MotorRight] = qmm_pkg::MixW'(thrust_q) + qmm_pkg::MixW'(pitch_t)
                               + qmm_pkg::MixW'(yaw_t);
    for (int m = 0; m < qmm_pkg::NumMotors; m++) begin
      if (mix[m] > 0) begin
        dem_d[m] = mix[m][qmm_pkg::DemW-1:0];
      end else begin
        dem_d[m] = '0;
      end
    end
  end

  assign valid_o = vld2_q;
  assign dem_o   = dem_q;

endmodule

`default_nettype wire

// ===== rtl/core/qmm_scale.sv =====
`default_nettype none

module qmm_scale (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       valid_i,
  input  wire qmm_pkg::demand_t [qmm_pkg::NumMotors-1:0]  dem_i,
  input  wire logic [qmm_pkg::CfgW-1:0]                   gain_i,
  output logic                                            valid_o,
  output qmm_pkg::rad_t [qmm_pkg::NumMotors-1:0]          rad_o
);

  logic [qmm_pkg::NumMotors-1:0][qmm_pkg::HiW-1:0] hi_d, hi_q;
  logic [qmm_pkg::NumMotors-1:0][qmm_pkg::LoW-1:0] lo_d, lo_q;
  qmm_pkg::rad_t [qmm_pkg::NumMotors-1:0]          rad_d, rad_q;
  logic [qmm_pkg::SumW-1:0]                        sum [qmm_pkg::NumMotors];
  logic [qmm_pkg::SW-1:0]                          s   [qmm_pkg::NumMotors];
  logic                                            vld3_q, vld4_q;

  // Split each demand into two partial products against the gain
  always_comb begin
    for (int m = 0; m < qmm_pkg::NumMotors; m++) begin
      hi_d[m] = qmm_pkg::HiW'(dem_i[m][qmm_pkg::DemW-1:32]) * qmm_pkg::HiW'(gain_i);
      lo_d[m] = qmm_pkg::LoW'(dem_i[m][31:0]) * qmm_pkg::LoW'(gain_i);
    end
  end

  // Recombine, drop 16 fraction bits, saturate S at 2^39, pad for the root
  always_comb begin
    for (int m = 0; m < qmm_pkg::NumMotors; m++) begin
      sum[m] = {hi_q[m], 32'b0} + qmm_pkg::SumW'(lo_q[m]);
      if (|sum[m][qmm_pkg::SumW-1:55]) begin
        s[m] = {1'b1, 39'b0};
      end else begin
        s[m] = {1'b0, sum[m][54:16]};
      end
      rad_d[m] = {2'b00, s[m], {qmm_pkg::SqPad{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld3_q <= valid_i;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    rad_q <= rad_d;
  end

  assign valid_o = vld4_q;
  assign rad_o   = rad_q;

endmodule

`default_nettype wire

// ===== rtl/core/qmm_sqrt.sv =====
`default_nettype none

module qmm_sqrt (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  input  wire qmm_pkg::rad_t [qmm_pkg::NumMotors-1:0]    rad_i,
  output logic                                           valid_o,
  output qmm_pkg::sq_root_t [qmm_pkg::NumMotors-1:0]     root_o
);

  localparam int unsigned NS = qmm_pkg::SqrtStages;

  logic                                          st_vld [NS+1];
  qmm_pkg::rad_t      [qmm_pkg::NumMotors-1:0]   st_rad [NS+1];
  qmm_pkg::root_acc_t [qmm_pkg::NumMotors-1:0]   st_acc [NS+1];

  assign st_vld[0] = valid_i;
  assign st_rad[0] = rad_i;
  assign st_acc[0] = '0;

  // Each stage settles two root bits for every lane
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                                        vld_q;
    qmm_pkg::rad_t      [qmm_pkg::NumMotors-1:0] rad_q;
    qmm_pkg::root_acc_t [qmm_pkg::NumMotors-1:0] acc_d, acc_q;

    always_comb begin
      for (int m = 0; m < qmm_pkg::NumMotors; m++) begin
        acc_d[m] = qmm_pkg::root_step(
                     qmm_pkg::root_step(st_acc[s][m],
                                        st_rad[s][m][qmm_pkg::RadW-1-4*s -: 2]),
                     st_rad[s][m][qmm_pkg::RadW-3-4*s -: 2]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= st_vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q <= st_rad[s];
      acc_q <= acc_d;
    end

    assign st_vld[s+1] = vld_q;
    assign st_rad[s+1] = rad_q;
    assign st_acc[s+1] = acc_q;
  end

  always_comb begin
    for (int m = 0; m < qmm_pkg::NumMotors; m++) begin
      root_o[m] = st_acc[NS][m].root;
    end
  end

  assign valid_o = st_vld[NS];

endmodule

`default_nettype wire

// ===== rtl/core/qmm_map.sv =====
`default_nettype none

module qmm_map (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  input  wire qmm_pkg::sq_root_t [qmm_pkg::NumMotors-1:0] root_i,
  output logic                                           valid_o,
  output logic [qmm_pkg::NumMotors-1:0][15:0]            cmd_o
);

  localparam int unsigned M = qmm_pkg::NumMotors;

  logic                                   vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic [M-1:0]                           lo_a_q, hi_a_q, lo_b_q, hi_b_q, lo_c_q, hi_c_q;
  logic [M-1:0]                           lo_d, hi_d;
  logic [M-1:0][qmm_pkg::VW-1:0]          v_d, v_a_q, v_b_q;
  logic [M-1:0][qmm_pkg::RcpW-1:0]        prod_d, prod_q;
  logic [M-1:0][qmm_pkg::EstW-1:0]        est_d, est_q;
  logic [M-1:0][qmm_pkg::RmW-1:0]         rem_d, rem_q;
  logic [M-1:0][15:0]                     cmd_d, cmd_q;
  logic signed [qmm_pkg::NW-1:0]          n   [M];
  logic signed [qmm_pkg::NW-1:0]          v   [M];
  logic [26:0]                            rm  [M];
  logic [16:0]                            r0  [M];

  // Centre the root, flag saturation, offset into a positive numerator
  always_comb begin
    for (int m = 0; m < M; m++) begin
      n[m]    = $signed({1'b0, root_i[m]}) - qmm_pkg::Centre;
      lo_d[m] = (n[m] <= -qmm_pkg::NLim);
      hi_d[m] = (n[m] >= qmm_pkg::NLim);
      v[m]    = n[m] + qmm_pkg::NLim + qmm_pkg::HalfSpan;
      v_d[m]  = v[m][qmm_pkg::VW-1:0];
    end
  end

  // Reciprocal product for the division by the span
  always_comb begin
    for (int m = 0; m < M; m++) begin
      prod_d[m] = qmm_pkg::RcpW'(v_a_q[m]) * qmm_pkg::RcpW'(qmm_pkg::RecipM);
    end
  end

  // Quotient estimate and its remainder
  always_comb begin
    for (int m = 0; m < M; m++) begin
      est_d[m] = prod_q[m][qmm_pkg::RcpW-1:qmm_pkg::RecipSh];
      rm[m]    = 27'(v_b_q[m]) - 27'(est_d[m]) * 27'(qmm_pkg::Span);
      rem_d[m] = rm[m][qmm_pkg::RmW-1:0];
    end
  end

  // Correct the estimate by one and apply saturation
  always_comb begin
    for (int m = 0; m < M; m++) begin
      r0[m] = 17'(est_q[m]) + 17'(rem_q[m] >= qmm_pkg::Span);
      if (lo_c_q[m]) begin
        cmd_d[m] = qmm_pkg::NegOne;
      end else if (hi_c_q[m]) begin
        cmd_d[m] = qmm_pkg::PosOne;
      end else begin
        cmd_d[m] = r0[m][15:0] - qmm_pkg::PosOne;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_a_q <= lo_d;
    hi_a_q <= hi_d;
    v_a_q  <= v_d;
    lo_b_q <= lo_a_q;
    hi_b_q <= hi_a_q;
    v_b_q  <= v_a_q;
    prod_q <= prod_d;
    lo_c_q <= lo_b_q;
    hi_c_q <= hi_b_q;
    est_q  <= est_d;
    rem_q  <= rem_d;
    cmd_q  <= cmd_d;
  end

  assign valid_o = vld_d_q;
  assign cmd_o   = cmd_q;

endmodule

`default_nettype wire
